// File: rtl/sukl_pkg.sv
// shared codes and field widths for the sorted unique key list
`default_nettype none

package sukl_pkg;

    localparam int KEY_W    = 32;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 3;
    localparam int POS_W    = 4;

    // request codes
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
    localparam logic [OP_W-1:0] OP_LIST   = 2'd2;
    // spare code, taken and dropped
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DELETED   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd4;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd5;
    localparam logic [STATUS_W-1:0] ST_ENTRY     = 3'd6;

    typedef logic signed [KEY_W-1:0] key_t;

endpackage

`default_nettype wire

// File: rtl/sukl_cell.sv
// one storage cell of the key chain, passing its key towards the head on each shift
`default_nettype none

module sukl_cell
(
    input  wire logic           clk,
    input  wire logic           shift,
    input  wire sukl_pkg::key_t key_in,
    output sukl_pkg::key_t      key_out
);

    sukl_pkg::key_t key_reg;

    // take the neighbour's key when the chain moves
    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            key_reg <= key_in;
        end
    end

    assign key_out = key_reg;

endmodule

`default_nettype wire

// File: rtl/sorted_unique_key_list.sv
// top level: sorted unique key list built as a rotating chain of key cells
`default_nettype none

// Holds up to DEPTH distinct signed 32-bit keys in ascending order in a chain
// of cells. Each accepted request (insert, delete, list) rotates the whole
// chain once through the head cell, one cell per cycle while the result side
// does not stall; the chain waits while a result cannot be loaded. Inserts
// and deletes are applied on the fly as keys pass the head, and their single
// result appears on the last rotation step. A list request emits one
// transaction per stored key as it passes the head (position, ascending,
// tlast on the final key) or a single empty status. Opcode 3 is taken and
// dropped with no result. A new request is taken only once the previous
// rotation has finished.

module sorted_unique_key_list
#(
    parameter int DEPTH = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // slave side: opcode [1:0], key [33:2], zero fill [39:34]
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,
    // master side: status [2:0], entry_key [34:3], position [38:35], zero fill [39]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,
    output logic             m_axis_tlast
);

    localparam int STEP_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(DEPTH);

    typedef enum logic [0:0] {
        IDLE,
        WALK
    } state_t;

    state_t                          state_reg;
    logic [sukl_pkg::OP_W-1:0]       op_reg;
    sukl_pkg::key_t                  key_reg;
    logic [STEP_W-1:0]               step_reg;
    logic [CNT_W-1:0]                count_reg;
    logic                            done_reg;
    logic [sukl_pkg::STATUS_W-1:0]   status_reg;
    logic                            delay_reg;
    logic                            skip_reg;
    sukl_pkg::key_t                  hold_reg;

    logic                            out_valid_reg;
    logic [sukl_pkg::STATUS_W-1:0]   out_status_reg;
    sukl_pkg::key_t                  out_key_reg;
    logic [sukl_pkg::POS_W-1:0]      out_pos_reg;
    logic                            out_last_reg;

    sukl_pkg::key_t                  chain [DEPTH];
    sukl_pkg::key_t                  tail_in;
    sukl_pkg::key_t                  slot;
    logic                            shift;

    logic [sukl_pkg::OP_W-1:0]       in_op;
    sukl_pkg::key_t                  in_key;
    logic                            in_take;

    logic [CNT_W-1:0]                step_cnt;
    logic [STEP_W+sukl_pkg::POS_W-1:0] step_ext;
    logic                            occ;
    logic                            last_step;
    logic                            is_list;
    logic                            list_nonempty;
    logic                            slot_eq;
    logic                            slot_lt;
    logic                            act;
    logic [sukl_pkg::STATUS_W-1:0]   act_status;
    logic                            ins_now;
    logic                            del_now;
    logic [sukl_pkg::STATUS_W-1:0]   miss_status;
    logic [sukl_pkg::STATUS_W-1:0]   final_status;
    logic                            emit;
    logic                            can_load;
    logic [sukl_pkg::STATUS_W-1:0]   emit_status;
    sukl_pkg::key_t                  emit_key;
    logic [sukl_pkg::POS_W-1:0]      emit_pos;
    logic                            emit_last;

    // request unpacking
    assign in_op   = s_axis_tdata[1:0];
    assign in_key  = s_axis_tdata[33:2];
    assign s_axis_tready = (state_reg == IDLE);
    assign in_take = s_axis_tvalid && s_axis_tready;

    // chain of cells, head at index 0, fed at the far end
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        sukl_pkg::key_t cell_in;
        if (i == DEPTH - 1)
        begin : g_tail
            assign cell_in = tail_in;
        end
        else
        begin : g_body
            assign cell_in = chain[i+1];
        end
        sukl_cell u_cell
        (
            .clk     (clk),
            .shift   (shift),
            .key_in  (cell_in),
            .key_out (chain[i])
        );
    end

    assign slot = chain[0];

    // head slot tests
    always_comb
    begin
        step_cnt      = CNT_W'(step_reg);
        step_ext      = {{sukl_pkg::POS_W{1'b0}}, step_reg};
        occ           = (step_cnt < count_reg);
        last_step     = (step_reg == LAST_STEP);
        is_list       = (op_reg == sukl_pkg::OP_LIST);
        list_nonempty = is_list && (count_reg != '0);
        slot_eq       = (slot == key_reg);
        slot_lt       = (slot < key_reg);
    end

    // insert or delete decision at the head slot
    always_comb
    begin
        act        = 1'b0;
        act_status = sukl_pkg::ST_INSERTED;
        ins_now    = 1'b0;
        del_now    = 1'b0;
        miss_status = sukl_pkg::ST_FULL;
        case (op_reg)
            sukl_pkg::OP_INSERT:
            begin
                act = !done_reg && (!occ || !slot_lt);
                if (occ && slot_eq)
                begin
                    act_status = sukl_pkg::ST_DUPLICATE;
                end
                else if (count_reg == FULL_CNT)
                begin
                    act_status = sukl_pkg::ST_FULL;
                end
                else
                begin
                    act_status = sukl_pkg::ST_INSERTED;
                end
                ins_now     = act && (act_status == sukl_pkg::ST_INSERTED);
                miss_status = sukl_pkg::ST_FULL;
            end
            sukl_pkg::OP_DELETE:
            begin
                act         = !done_reg && occ && slot_eq;
                act_status  = sukl_pkg::ST_DELETED;
                del_now     = act;
                miss_status = (count_reg == '0) ? sukl_pkg::ST_EMPTY
                                                : sukl_pkg::ST_NOTFOUND;
            end
            default:
            begin
                act         = 1'b0;
                miss_status = sukl_pkg::ST_EMPTY;
            end
        endcase
        if (done_reg)
        begin
            final_status = status_reg;
        end
        else if (act)
        begin
            final_status = act_status;
        end
        else
        begin
            final_status = miss_status;
        end
    end

    // value fed into the far end of the chain
    always_comb
    begin
        if (ins_now)
        begin
            tail_in = key_reg;
        end
        else if (delay_reg)
        begin
            tail_in = hold_reg;
        end
        else if (del_now || skip_reg)
        begin
            tail_in = chain[1];
        end
        else
        begin
            tail_in = slot;
        end
    end

    // result selection for this rotation step
    always_comb
    begin
        if (list_nonempty)
        begin
            emit        = occ;
            emit_status = sukl_pkg::ST_ENTRY;
            emit_key    = slot;
            emit_pos    = step_ext[sukl_pkg::POS_W-1:0];
            emit_last   = (step_cnt == (count_reg - 1'b1));
        end
        else
        begin
            emit        = last_step;
            emit_status = final_status;
            emit_key    = is_list ? '0 : key_reg;
            emit_pos    = '0;
            emit_last   = 1'b1;
        end
    end

    assign can_load = !out_valid_reg || m_axis_tready;
    assign shift    = (state_reg == WALK) && (!emit || can_load);

    // sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= IDLE;
            op_reg         <= '0;
            key_reg        <= '0;
            step_reg       <= '0;
            count_reg      <= '0;
            done_reg       <= 1'b0;
            status_reg     <= '0;
            delay_reg      <= 1'b0;
            skip_reg       <= 1'b0;
            hold_reg       <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= '0;
            out_key_reg    <= '0;
            out_pos_reg    <= '0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            // result transaction register
            if (shift && emit)
            begin
                out_valid_reg  <= 1'b1;
                out_status_reg <= emit_status;
                out_key_reg    <= emit_key;
                out_pos_reg    <= emit_pos;
                out_last_reg   <= emit_last;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                IDLE:
                begin
                    if (in_take && (in_op != sukl_pkg::OP_UNUSED))
                    begin
                        state_reg <= WALK;
                        op_reg    <= in_op;
                        key_reg   <= in_key;
                        step_reg  <= '0;
                        done_reg  <= 1'b0;
                        delay_reg <= 1'b0;
                        skip_reg  <= 1'b0;
                    end
                end
                WALK:
                begin
                    if (shift)
                    begin
                        if (act)
                        begin
                            done_reg   <= 1'b1;
                            status_reg <= act_status;
                        end
                        if (ins_now || delay_reg)
                        begin
                            hold_reg <= slot;
                        end
                        if (ins_now)
                        begin
                            delay_reg <= 1'b1;
                        end
                        if (del_now)
                        begin
                            skip_reg <= 1'b1;
                        end
                        if (last_step)
                        begin
                            state_reg <= IDLE;
                            step_reg  <= '0;
                            if (ins_now || delay_reg)
                            begin
                                count_reg <= count_reg + 1'b1;
                            end
                            else if (del_now || skip_reg)
                            begin
                                count_reg <= count_reg - 1'b1;
                            end
                        end
                        else
                        begin
                            step_reg <= step_reg + 1'b1;
                        end
                    end
                end
                default:
                begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

    // result packing
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_pos_reg, out_key_reg, out_status_reg};
    assign m_axis_tlast  = out_last_reg;

endmodule

`default_nettype wire
